// ===== hdl/msd_pkg.sv =====
package msd_pkg;

   // Smallest legal message body: stored CRC, magic, attributes and the two length words.
   localparam int unsigned MIN_BODY = 14;

   // The offset and size words together take up this many bytes in front of the body.
   localparam int unsigned HEAD_BYTES = 12;

   // Number of offset bytes.
   localparam int unsigned OFFSET_BYTES = 8;

   // Reflected CRC-32 polynomial.
   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

   // Length value that stands for an absent key or value.
   localparam logic [31:0] LEN_ABSENT = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_CRC_BAD   = 3'd1,
      ST_BAD_SIZE  = 3'd2,
      ST_BAD_KEY   = 3'd3,
      ST_BAD_VALUE = 3'd4,
      ST_TRUNCATED = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      PH_OFFSET,
      PH_SIZE,
      PH_BODY,
      PH_DROP
   } phase_type;

   // One result, as it moves from the parser to the result register.
   typedef struct packed {
      logic        valid;
      status_type  status;
      logic [63:0] msg_offset;
      logic [31:0] msg_position;
      logic [31:0] msg_size;
      logic [7:0]  attributes;
      logic [30:0] key_len;
      logic [30:0] value_len;
      logic        crc_ok;
      logic        set_done;
   } result_type;

   // Advances the CRC register by one byte, least significant bit first.
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int k = 0; k < 8; k++) begin
         c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
      end
      return c;
   endfunction

   // An absent length counts as zero.
   function automatic logic [31:0] map_len(input logic [31:0] v);
      return (v == LEN_ABSENT) ? 32'd0 : v;
   endfunction

endpackage

// ===== hdl/msd_core.sv =====
module msd_core
   import msd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step_en,
   input  logic [7:0] data_byte,
   input  logic       set_last,
   output result_type result
);

   phase_type   phase_ff, phase_in;
   logic [31:0] cnt_ff, cnt_in;
   logic [31:0] pos_ff, pos_in;
   logic [31:0] start_ff, start_in;
   logic [63:0] off_ff, off_in;
   logic [31:0] size_ff, size_in;
   logic [31:0] crc_ff, crc_in;
   logic [31:0] stored_ff, stored_in;
   logic [7:0]  attr_ff, attr_in;
   logic [31:0] key_ff, key_in;
   logic [31:0] val_ff, val_in;

   logic        first;
   logic [31:0] body_idx;
   logic [31:0] key_cur;
   logic [33:0] idx_x;
   logic [33:0] key_cur_x;
   logic [33:0] size_x;
   logic        value_win;
   logic [31:0] key_fin;
   logic [31:0] val_fin;
   logic        msg_end;
   logic        crc_match;
   logic        key_bad;
   logic        val_bad;
   logic        emit;
   logic        close_set;
   status_type  status;
   logic [30:0] klen;
   logic [30:0] vlen;
   logic        crc_ok;

   // Parser state. Message fields need no reset: the first byte of each message clears them.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_OFFSET;
         cnt_ff   <= '0;
         pos_ff   <= '0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         pos_ff   <= pos_in;
      end
      if (step_en) begin
         start_ff  <= start_in;
         off_ff    <= off_in;
         size_ff   <= size_in;
         crc_ff    <= crc_in;
         stored_ff <= stored_in;
         attr_ff   <= attr_in;
         key_ff    <= key_in;
         val_ff    <= val_in;
      end
   end

   assign first     = (phase_ff == PH_OFFSET) && (cnt_ff == 32'd0);
   assign body_idx  = cnt_ff - 32'(HEAD_BYTES);
   assign key_cur   = map_len(key_ff);
   assign idx_x     = {2'b00, body_idx};
   assign key_cur_x = {2'b00, key_cur};
   // Only read in the body phase, where the size is known to be positive.
   assign size_x    = {2'b00, size_ff};

   // The value length word sits just after the key, provided the key fits in the body.
   assign value_win = (body_idx >= 32'd10) && !key_cur[31]
                      && (key_cur_x + 34'(MIN_BODY) <= size_x)
                      && (idx_x >= key_cur_x + 34'd10)
                      && (idx_x <= key_cur_x + 34'd13);

   always_comb begin
      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      pos_in    = pos_ff + 32'd1;
      start_in  = first ? pos_ff : start_ff;
      off_in    = first ? 64'd0 : off_ff;
      size_in   = first ? 32'd0 : size_ff;
      crc_in    = first ? 32'hFFFF_FFFF : crc_ff;
      stored_in = first ? 32'd0 : stored_ff;
      attr_in   = first ? 8'd0 : attr_ff;
      key_in    = first ? 32'd0 : key_ff;
      val_in    = first ? 32'd0 : val_ff;
      key_fin   = '0;
      val_fin   = '0;
      msg_end   = 1'b0;
      crc_match = 1'b0;
      key_bad   = 1'b0;
      val_bad   = 1'b0;
      emit      = 1'b0;
      close_set = 1'b0;
      status    = ST_OK;
      klen      = '0;
      vlen      = '0;
      crc_ok    = 1'b0;

      case (phase_ff)
         PH_DROP: begin
            if (set_last) begin
               close_set = 1'b1;
            end
         end
         PH_OFFSET: begin
            off_in = {off_in[55:0], data_byte};
            cnt_in = cnt_ff + 32'd1;
            if (cnt_in == 32'(OFFSET_BYTES)) begin
               phase_in = PH_SIZE;
            end
            if (set_last) begin
               emit   = 1'b1;
               status = ST_TRUNCATED;
            end
         end
         PH_SIZE: begin
            size_in = {size_ff[23:0], data_byte};
            cnt_in  = cnt_ff + 32'd1;
            if ((cnt_in == 32'(HEAD_BYTES)) && ($signed(size_in) < $signed(32'(MIN_BODY)))) begin
               emit   = 1'b1;
               status = ST_BAD_SIZE;
            end else begin
               if (cnt_in == 32'(HEAD_BYTES)) begin
                  phase_in = PH_BODY;
               end
               if (set_last) begin
                  emit   = 1'b1;
                  status = ST_TRUNCATED;
               end
            end
         end
         PH_BODY: begin
            cnt_in = cnt_ff + 32'd1;
            if (body_idx < 32'd4) begin
               stored_in = {stored_ff[23:0], data_byte};
            end else begin
               crc_in = crc_byte(crc_ff, data_byte);
            end
            if (body_idx == 32'd5) begin
               attr_in = data_byte;
            end
            if ((body_idx >= 32'd6) && (body_idx <= 32'd9)) begin
               key_in = {key_ff[23:0], data_byte};
            end
            if (value_win) begin
               val_in = {val_ff[23:0], data_byte};
            end

            key_fin   = map_len(key_in);
            val_fin   = map_len(val_in);
            msg_end   = (cnt_in == size_ff + 32'(HEAD_BYTES));
            crc_match = (~crc_in == stored_in);
            key_bad   = key_fin[31] || ({2'b00, key_fin} + 34'(MIN_BODY) > size_x);
            val_bad   = val_fin[31]
                        || ({2'b00, key_fin} + {2'b00, val_fin} + 34'(MIN_BODY) != size_x);

            if (msg_end) begin
               emit = 1'b1;
               if (!crc_match) begin
                  status = ST_CRC_BAD;
               end else begin
                  crc_ok = 1'b1;
                  klen   = key_fin[30:0];
                  if (key_bad) begin
                     status = ST_BAD_KEY;
                  end else if (val_bad) begin
                     status = ST_BAD_VALUE;
                  end else begin
                     status = ST_OK;
                     vlen   = val_fin[30:0];
                  end
               end
            end else if (set_last) begin
               emit   = 1'b1;
               status = ST_TRUNCATED;
            end
         end
         default: begin
            close_set = set_last;
         end
      endcase

      if (emit) begin
         if (set_last) begin
            close_set = 1'b1;
         end else if ((status == ST_OK) || (status == ST_CRC_BAD)) begin
            phase_in = PH_OFFSET;
            cnt_in   = '0;
         end else begin
            phase_in = PH_DROP;
         end
      end
      if (close_set) begin
         phase_in = PH_OFFSET;
         cnt_in   = '0;
         pos_in   = '0;
      end

      result.valid        = emit;
      result.status       = status;
      result.msg_offset   = off_in;
      result.msg_position = start_in;
      result.msg_size     = size_in;
      result.attributes   = attr_in;
      result.key_len      = klen;
      result.value_len    = vlen;
      result.crc_ok       = crc_ok;
      result.set_done     = emit && set_last;
   end

endmodule

// ===== hdl/message_set_deframer_crc_check.sv =====
// Message-set deframer with CRC-32 check. The block takes one byte of a message set per
// request and reports each message as it completes: offset, start position within the set,
// size, attributes, key and value lengths and whether the standard CRC-32 over the body
// (after the stored CRC) matched. A size below fourteen is reported as soon as the size word
// is in; a set that ends inside a message is reported as truncated. After any error other
// than a CRC mismatch the rest of the set is dropped silently up to and including its last
// byte. Throughput is one byte per clock cycle with no bubbles while the receiver does not
// stall; each byte is held in the input register and its result, if any, is then registered
// in the result register. The parser step between the two registers includes an eight-bit
// unrolled CRC update and the 34-bit length compares.
module message_set_deframer_crc_check
   import msd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_set_last,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic signed [63:0] rsp_msg_offset,
   output logic [31:0] rsp_msg_position,
   output logic signed [31:0] rsp_msg_size,
   output logic [7:0]  rsp_attributes,
   output logic [30:0] rsp_key_len,
   output logic [30:0] rsp_value_len,
   output logic        rsp_crc_ok,
   output logic        rsp_set_done
);

   // Input register: one byte of the set waiting for the parser.
   logic       in_valid_ff;
   logic [7:0] in_data_ff;
   logic       in_last_ff;

   // Result register towards the consumer.
   result_type rsp_ff;
   result_type step_result;

   // The whole pipeline moves whenever the result register is free or is being emptied.
   logic advance;
   logic step_en;
   logic req_take;

   assign advance   = !rsp_ff.valid || !rsp_stall;
   assign step_en   = advance && in_valid_ff;
   // A new request can enter whenever the input register will be empty at the next edge.
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
      if (req_take) begin
         in_data_ff <= req_data_byte;
         in_last_ff <= req_set_last;
      end
   end

   // The parser holds the whole per-set state and works out the next state and any result
   // for the byte in the input register combinationally.
   msd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_en),
      .data_byte (in_data_ff),
      .set_last  (in_last_ff),
      .result    (step_result)
   );

   // Only the valid flag of the result register is control state; the payload follows it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_ff.valid <= 1'b0;
      end else if (advance) begin
         rsp_ff.valid <= step_en && step_result.valid;
      end
      if (step_en && step_result.valid) begin
         rsp_ff.status       <= step_result.status;
         rsp_ff.msg_offset   <= step_result.msg_offset;
         rsp_ff.msg_position <= step_result.msg_position;
         rsp_ff.msg_size     <= step_result.msg_size;
         rsp_ff.attributes   <= step_result.attributes;
         rsp_ff.key_len      <= step_result.key_len;
         rsp_ff.value_len    <= step_result.value_len;
         rsp_ff.crc_ok       <= step_result.crc_ok;
         rsp_ff.set_done     <= step_result.set_done;
      end
   end

   assign rsp_valid        = rsp_ff.valid;
   assign rsp_status       = rsp_ff.status;
   assign rsp_msg_offset   = $signed(rsp_ff.msg_offset);
   assign rsp_msg_position = rsp_ff.msg_position;
   assign rsp_msg_size     = $signed(rsp_ff.msg_size);
   assign rsp_attributes   = rsp_ff.attributes;
   assign rsp_key_len      = rsp_ff.key_len;
   assign rsp_value_len    = rsp_ff.value_len;
   assign rsp_crc_ok       = rsp_ff.crc_ok;
   assign rsp_set_done     = rsp_ff.set_done;

endmodule

// ===== hdl/msd_chk.sv =====
module msd_chk
   import msd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [7:0]  req_data_byte,
   input logic        req_set_last,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_status,
   input logic signed [63:0] rsp_msg_offset,
   input logic [31:0] rsp_msg_position,
   input logic signed [31:0] rsp_msg_size,
   input logic [7:0]  rsp_attributes,
   input logic [30:0] rsp_key_len,
   input logic [30:0] rsp_value_len,
   input logic        rsp_crc_ok,
   input logic        rsp_set_done
);

   // A stalled result holds its status and message position.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_msg_position))
      else $error("stalled result changed");

   // A good message carries a matching CRC.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_OK) |-> rsp_crc_ok)
      else $error("ok result without matching CRC");

   // Truncation always closes the set and carries no lengths.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_TRUNCATED)
      |-> rsp_set_done && !rsp_crc_ok && (rsp_key_len == 31'd0) && (rsp_value_len == 31'd0))
      else $error("malformed truncation result");

   // A bad size is only reported for sizes below the minimum body.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_BAD_SIZE)
      |-> (rsp_msg_size < 32'sd14) && !rsp_crc_ok && (rsp_key_len == 31'd0))
      else $error("bad size result with legal size");

   // A CRC mismatch carries crc_ok low, reports no lengths and has a size of at least the minimum body.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_CRC_BAD)
      |-> !rsp_crc_ok && (rsp_key_len == 31'd0) && (rsp_value_len == 31'd0)
          && (rsp_msg_size >= 32'sd14))
      else $error("malformed CRC mismatch result");

endmodule

bind message_set_deframer_crc_check msd_chk u_msd_chk (.*);

// ===== dv/tb_message_set_deframer_crc_check.sv =====
`timescale 1ns / 1ps

module tb_message_set_deframer_crc_check;
   import msd_pkg::*;

   // Signed copies of the package sizes. The package holds them as unsigned, and mixing them
   // with signed lengths would turn every compare unsigned.
   localparam longint BODY_MIN = longint'(MIN_BODY);
   localparam longint HEAD_LEN = longint'(HEAD_BYTES);
   localparam int     HEAD_N = HEAD_BYTES;
   localparam int     BODY_N = MIN_BODY;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 20;
   localparam int IDLE_PERCENT = 34;
   localparam int PARSED_TARGET = 640;
   localparam int REPORT_TARGET = 25;
   localparam int CALM_BYTES = 100;

   // One message as the stimulus sees it. The length words and the number of key and value
   // bytes that follow them are kept apart, so that lengths which disagree with the body can
   // be sent. The size word is the true body length plus size_delta. A cut of one or more
   // ends the set after that many bytes of the message. Where typed is set, the status of the
   // last result that the message causes is written into the row by hand.
   typedef struct packed {
      logic [63:0] offset;
      logic [7:0]  attr;
      logic [31:0] key_field;
      int          key_n;
      logic [31:0] value_field;
      int          value_n;
      int          size_delta;
      bit          crc_bad;
      int          cut;
      bit          ends_set;
      bit          typed;
      status_type  status;
   } msg_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_set_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic signed [63:0] rsp_msg_offset;
   logic [31:0] rsp_msg_position;
   logic signed [31:0] rsp_msg_size;
   logic [7:0]  rsp_attributes;
   logic [30:0] rsp_key_len;
   logic [30:0] rsp_value_len;
   logic        rsp_crc_ok;
   logic        rsp_set_done;

   // Parser state of the predictor.
   phase_type   ps_phase;
   logic [31:0] ps_count;
   logic [31:0] ps_pos;
   logic [31:0] ps_start;
   logic [63:0] ps_offset;
   logic [31:0] ps_size;
   logic [31:0] ps_crc;
   logic [31:0] ps_crc_stored;
   logic [7:0]  ps_attr;
   logic [31:0] ps_key;
   logic [31:0] ps_value;

   result_type  reports_due[$];
   msg_row_type directed_rows[$];
   logic [7:0]  frame_q[$];

   bit          calm = 1'b0;
   int          mismatches = 0;
   int          cycle_count = 0;
   int          requests_taken = 0;
   int          parsed_bytes = 0;
   int          reports_made = 0;
   int          results_checked = 0;
   int          status_tally[0:5] = '{default: 0};
   status_type  last_status = ST_OK;

   message_set_deframer_crc_check DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_set_last     (req_set_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_msg_offset   (rsp_msg_offset),
      .rsp_msg_position (rsp_msg_position),
      .rsp_msg_size     (rsp_msg_size),
      .rsp_attributes   (rsp_attributes),
      .rsp_key_len      (rsp_key_len),
      .rsp_value_len    (rsp_value_len),
      .rsp_crc_ok       (rsp_crc_ok),
      .rsp_set_done     (rsp_set_done)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------------------

   // Reflected CRC-32, one byte at a time, low bit first.
   function automatic logic [31:0] crc32_update(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      return c;
   endfunction

   // A length word read as signed, where minus one stands for an absent field of length zero.
   function automatic longint len_of(input logic [31:0] v);
      longint x;
      x = longint'($signed(v));
      return (x == -1) ? longint'(0) : x;
   endfunction

   function automatic void start_message();
      ps_count = '0;
      ps_start = ps_pos;
      ps_offset = '0;
      ps_size = '0;
      ps_crc = '1;
      ps_crc_stored = '0;
      ps_attr = '0;
      ps_key = '0;
      ps_value = '0;
   endfunction

   function automatic void close_set();
      ps_phase = PH_OFFSET;
      ps_count = '0;
      ps_pos = '0;
   endfunction

   function automatic void reset_model();
      ps_pos = '0;
      start_message();
      close_set();
   endfunction

   // After a hard error the rest of the set is skipped, unless this byte closes it anyway.
   function automatic void stop_parsing(input logic last);
      if (last) begin
         close_set();
      end else begin
         ps_phase = PH_DROP;
      end
   endfunction

   function automatic result_type make_report(input status_type st, input longint klen,
                                              input longint vlen, input logic ok,
                                              input logic done);
      result_type r;
      r.valid = 1'b1;
      r.status = st;
      r.msg_offset = ps_offset;
      r.msg_position = ps_start;
      r.msg_size = ps_size;
      r.attributes = ps_attr;
      r.key_len = klen[30:0];
      r.value_len = vlen[30:0];
      r.crc_ok = ok;
      r.set_done = done;
      return r;
   endfunction

   // Moves the predicted parser on by one byte; returns 1 when the byte completes a result.
   function automatic bit deframe_byte(input logic [7:0] b, input logic last,
                                       output result_type r);
      longint size_v;
      longint kx;
      longint vx;
      longint d;
      longint i;
      r = '0;
      if (ps_phase == PH_DROP) begin
         ps_pos = ps_pos + 1;
         if (last) close_set();
         return 1'b0;
      end
      if (ps_phase == PH_OFFSET && ps_count == 0) start_message();
      ps_pos = ps_pos + 1;

      if (ps_phase == PH_OFFSET) begin
         ps_offset = {ps_offset[55:0], b};
         ps_count = ps_count + 1;
         if (ps_count >= OFFSET_BYTES) ps_phase = PH_SIZE;
      end else if (ps_phase == PH_SIZE) begin
         ps_size = {ps_size[23:0], b};
         ps_count = ps_count + 1;
         if (ps_count >= HEAD_BYTES) begin
            size_v = longint'($signed(ps_size));
            if (size_v < BODY_MIN) begin
               r = make_report(ST_BAD_SIZE, 0, 0, 1'b0, last);
               stop_parsing(last);
               return 1'b1;
            end
            ps_phase = PH_BODY;
         end
      end else begin
         size_v = longint'($signed(ps_size));
         i = longint'(ps_count - HEAD_BYTES);
         ps_count = ps_count + 1;
         if (i < 4) begin
            ps_crc_stored = {ps_crc_stored[23:0], b};
         end else begin
            ps_crc = crc32_update(ps_crc, b);
         end
         if (i == 5) ps_attr = b;
         if (i >= 6 && i <= 9) ps_key = {ps_key[23:0], b};
         // The value length is only gathered once the key length is known to fit.
         if (i >= 10) begin
            kx = len_of(ps_key);
            if (kx >= 0 && BODY_MIN + kx <= size_v) begin
               d = i - 10 - kx;
               if (d >= 0 && d <= 3) ps_value = {ps_value[23:0], b};
            end
         end
         if (longint'(ps_count) == HEAD_LEN + size_v) begin
            if (~ps_crc != ps_crc_stored) begin
               r = make_report(ST_CRC_BAD, 0, 0, 1'b0, last);
            end else begin
               kx = len_of(ps_key);
               if (kx < 0 || BODY_MIN + kx > size_v) begin
                  r = make_report(ST_BAD_KEY, kx, 0, 1'b1, last);
                  stop_parsing(last);
                  return 1'b1;
               end
               vx = len_of(ps_value);
               if (vx < 0 || BODY_MIN + kx + vx != size_v) begin
                  r = make_report(ST_BAD_VALUE, kx, 0, 1'b1, last);
                  stop_parsing(last);
                  return 1'b1;
               end
               r = make_report(ST_OK, kx, vx, 1'b1, last);
            end
            // A good message or a bad CRC leaves the parser ready for the next message.
            if (last) begin
               close_set();
            end else begin
               ps_phase = PH_OFFSET;
               ps_count = '0;
            end
            return 1'b1;
         end
      end

      if (last) begin
         r = make_report(ST_TRUNCATED, 0, 0, 1'b0, 1'b1);
         close_set();
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Message building
   // ---------------------------------------------------------------------------------------

   function automatic msg_row_type plan(input logic [63:0] offset, input logic [7:0] attr,
                                        input logic [31:0] key_field, input int key_n,
                                        input logic [31:0] value_field, input int value_n,
                                        input int size_delta, input bit crc_bad,
                                        input int cut, input bit ends_set, input bit typed,
                                        input status_type status);
      msg_row_type m;
      m.offset = offset;
      m.attr = attr;
      m.key_field = key_field;
      m.key_n = key_n;
      m.value_field = value_field;
      m.value_n = value_n;
      m.size_delta = size_delta;
      m.crc_bad = crc_bad;
      m.cut = cut;
      m.ends_set = ends_set;
      m.typed = typed;
      m.status = status;
      return m;
   endfunction

   // Lays one message out in frame_q: offset, size, stored CRC and then the body that the
   // CRC covers. Key, value and magic bytes carry random content.
   function automatic void frame_message(input msg_row_type m);
      logic [7:0]  tail[$];
      logic [31:0] crc;
      logic [31:0] sz;
      tail = {};
      tail.push_back(8'($urandom_range(255)));
      tail.push_back(m.attr);
      for (int j = 3; j >= 0; j--) tail.push_back(m.key_field[8*j +: 8]);
      for (int j = 0; j < m.key_n; j++) tail.push_back(8'($urandom_range(255)));
      for (int j = 3; j >= 0; j--) tail.push_back(m.value_field[8*j +: 8]);
      for (int j = 0; j < m.value_n; j++) tail.push_back(8'($urandom_range(255)));
      crc = '1;
      foreach (tail[j]) crc = crc32_update(crc, tail[j]);
      crc = ~crc;
      if (m.crc_bad) crc = crc ^ (32'd1 << $urandom_range(31));
      sz = 32'(tail.size() + 4) + 32'(m.size_delta);
      frame_q = {};
      for (int j = 7; j >= 0; j--) frame_q.push_back(m.offset[8*j +: 8]);
      for (int j = 3; j >= 0; j--) frame_q.push_back(sz[8*j +: 8]);
      for (int j = 3; j >= 0; j--) frame_q.push_back(crc[8*j +: 8]);
      foreach (tail[j]) frame_q.push_back(tail[j]);
   endfunction

   // Mostly well-formed messages with random content; the rest carry one fault each.
   function automatic msg_row_type random_row(input bit closes);
      msg_row_type m;
      int kind;
      int span;
      m = plan({$urandom, $urandom}, 8'($urandom_range(255)), 0, 0, 0, 0, 0, 1'b0, -1,
               closes, 1'b0, ST_OK);
      m.key_n = $urandom_range(6);
      m.key_field = m.key_n;
      m.value_n = $urandom_range(10);
      m.value_field = m.value_n;
      if ($urandom_range(9) == 0) begin
         m.key_field = LEN_ABSENT;
         m.key_n = 0;
      end
      if ($urandom_range(9) == 0) begin
         m.value_field = LEN_ABSENT;
         m.value_n = 0;
      end
      span = BODY_N + m.key_n + m.value_n;
      kind = $urandom_range(99);
      if (kind >= 94) begin
         m.cut = $urandom_range(1, HEAD_N + span - 1);
      end else if (kind >= 90) begin
         // Size word below the minimum, now and then the most negative value.
         if ($urandom_range(3) == 0) begin
            m.size_delta = 32'h8000_0000 - span;
         end else begin
            m.size_delta = $urandom_range(13) - span;
         end
      end else if (kind >= 86) begin
         m.size_delta = ($urandom_range(1) ? 1 : -1) * int'($urandom_range(1, 4));
      end else if (kind >= 82) begin
         m.value_field = $urandom_range(1) ? (32'h8000_0000 | $urandom)
                                           : m.value_n + 1 + $urandom_range(20);
      end else if (kind >= 78) begin
         m.key_field = $urandom_range(1) ? (32'h8000_0000 | $urandom)
                                         : m.key_n + m.value_n + 1 + $urandom_range(20);
      end else if (kind >= 70) begin
         m.crc_bad = 1'b1;
      end
      return m;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------------------------

   // Offers one byte, holds it steady while the block stalls, and on acceptance runs it
   // through the predictor. Every call starts and ends just after a rising edge, so valid
   // gets at most one assignment per time step.
   task automatic send_byte(input logic [7:0] b, input logic last);
      result_type r;
      bit live;
      while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_set_last <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      requests_taken++;
      live = (ps_phase != PH_DROP);
      if (live) parsed_bytes++;
      if (deframe_byte(b, last, r)) begin
         reports_due.push_back(r);
         reports_made++;
         status_tally[r.status]++;
         last_status = r.status;
      end
   endtask

   task automatic send_row(input msg_row_type m);
      int n;
      bit closes;
      frame_message(m);
      n = frame_q.size();
      closes = m.ends_set;
      if (m.cut >= 0) begin
         closes = 1'b1;
         if (m.cut < n) n = m.cut;
      end
      for (int j = 0; j < n; j++) send_byte(frame_q[j], closes && (j == n - 1));
   endtask

   // ---------------------------------------------------------------------------------------
   // Result side
   // ---------------------------------------------------------------------------------------

   // The receiver stalls at random, apart from the calm stretch of the run.
   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
   end

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   // Each accepted result is held against the oldest outstanding prediction.
   always @(posedge clock) begin : result_check
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (reports_due.size() == 0) begin
            mismatches++;
            $display("%0t ns: unexpected result, expected none, actual status %0d",
                     $time, rsp_status);
         end else begin
            want = reports_due.pop_front();
            results_checked++;
            check_field("status", want.status, rsp_status);
            check_field("msg_offset", want.msg_offset, rsp_msg_offset);
            check_field("msg_position", want.msg_position, rsp_msg_position);
            check_field("msg_size", want.msg_size, $unsigned(rsp_msg_size));
            check_field("attributes", want.attributes, rsp_attributes);
            check_field("key_len", want.key_len, rsp_key_len);
            check_field("value_len", want.value_len, rsp_value_len);
            check_field("crc_ok", want.crc_ok, rsp_crc_ok);
            check_field("set_done", want.set_done, rsp_set_done);
         end
      end
   end

   // The run is bounded in cycles; a hang anywhere ends here.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   // ---------------------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------------------

   initial begin : stimulus
      msg_row_type m;
      int made;
      int n;
      int calm_start;

      // Directed messages. A status is typed in only where the outcome is plain from the
      // message itself; every row is checked field by field through the predictor as well.
      // Columns: offset, attributes, key word, key bytes, value word, value bytes,
      // size adjustment, corrupt CRC, cut, ends set, typed, status.
      // The shortest legal message, with both key and value absent.
      directed_rows.push_back(plan(64'h0, 8'h00, LEN_ABSENT, 0, LEN_ABSENT, 0, 0, 1'b0, -1,
                                   1'b0, 1'b1, ST_OK));
      // Offset and attributes at all ones; this one closes the first set.
      directed_rows.push_back(plan('1, 8'hFF, 3, 3, 5, 5, 0, 1'b0, -1, 1'b1, 1'b1, ST_OK));
      directed_rows.push_back(plan(64'h8000_0000_0000_0000, 8'h01, 0, 0, LEN_ABSENT, 0, 0,
                                   1'b0, -1, 1'b0, 1'b1, ST_OK));
      // A CRC mismatch is reported but parsing carries on with the next message.
      directed_rows.push_back(plan(64'h0123_4567_89AB_CDEF, 8'h80, 2, 2, 2, 2, 0, 1'b1, -1,
                                   1'b0, 1'b1, ST_CRC_BAD));
      directed_rows.push_back(plan(64'h7FFF_FFFF_FFFF_FFFF, 8'h7F, 6, 6, 8, 8, 0, 1'b0, -1,
                                   1'b1, 1'b1, ST_OK));
      // Negative key length other than minus one, then a message that is dropped silently
      // up to the byte that closes the set.
      directed_rows.push_back(plan(64'h10, 8'h22, 32'hFFFF_FFFE, 0, 0, 0, 0, 1'b0, -1, 1'b0,
                                   1'b1, ST_BAD_KEY));
      directed_rows.push_back(plan(64'h11, 8'h33, 1, 1, 1, 1, 0, 1'b0, -1, 1'b1, 1'b0,
                                   ST_OK));
      // Key longer than the message, on the set's last byte.
      directed_rows.push_back(plan(64'h12, 8'h44, 40, 0, 0, 0, 0, 1'b0, -1, 1'b1, 1'b1,
                                   ST_BAD_KEY));
      directed_rows.push_back(plan(64'h13, 8'h55, 1, 1, 32'hFFFF_FFFE, 0, 0, 1'b0, -1, 1'b1,
                                   1'b1, ST_BAD_VALUE));
      directed_rows.push_back(plan(64'h14, 8'h66, 0, 0, 7, 3, 0, 1'b0, -1, 1'b1, 1'b1,
                                   ST_BAD_VALUE));
      // Size one below the minimum, then a dropped message that closes the set.
      directed_rows.push_back(plan(64'h15, 8'h77, LEN_ABSENT, 0, LEN_ABSENT, 0, -1, 1'b0, -1,
                                   1'b0, 1'b1, ST_BAD_SIZE));
      directed_rows.push_back(plan(64'h16, 8'h78, LEN_ABSENT, 0, LEN_ABSENT, 0, 0, 1'b0, -1,
                                   1'b1, 1'b0, ST_OK));
      // Most negative size word.
      directed_rows.push_back(plan(64'h17, 8'h88, LEN_ABSENT, 0, LEN_ABSENT, 0,
                                   32'h7FFF_FFF2, 1'b0, -1, 1'b1, 1'b1, ST_BAD_SIZE));
      // A bad size on the set's final byte closes the set at once.
      directed_rows.push_back(plan(64'h18, 8'h99, LEN_ABSENT, 0, LEN_ABSENT, 0, -3, 1'b0, 12,
                                   1'b1, 1'b1, ST_BAD_SIZE));
      // Largest size word, so the set ends inside the body.
      directed_rows.push_back(plan(64'h19, 8'hAA, LEN_ABSENT, 0, LEN_ABSENT, 0,
                                   32'h7FFF_FFF1, 1'b0, 20, 1'b1, 1'b1, ST_TRUNCATED));
      // Truncation after one byte, after the whole offset, inside the size word and on the
      // first body byte.
      directed_rows.push_back(plan(64'h1A, 8'h01, 0, 0, 0, 0, 0, 1'b0, 1, 1'b1, 1'b1,
                                   ST_TRUNCATED));
      directed_rows.push_back(plan(64'h1B, 8'h02, 0, 0, 0, 0, 0, 1'b0, 8, 1'b1, 1'b1,
                                   ST_TRUNCATED));
      directed_rows.push_back(plan(64'h1C, 8'h03, 0, 0, 0, 0, 0, 1'b0, 10, 1'b1, 1'b1,
                                   ST_TRUNCATED));
      directed_rows.push_back(plan(64'h1D, 8'h04, 0, 0, 0, 0, 0, 1'b0, 13, 1'b1, 1'b1,
                                   ST_TRUNCATED));
      // Size words that disagree with the body, so that message boundaries slip.
      directed_rows.push_back(plan(64'h1E, 8'hBB, 1, 1, 1, 1, 2, 1'b0, -1, 1'b0, 1'b0,
                                   ST_OK));
      directed_rows.push_back(plan(64'h1F, 8'hCC, 2, 2, 3, 3, 0, 1'b0, -1, 1'b1, 1'b0,
                                   ST_OK));
      directed_rows.push_back(plan(64'h20, 8'hDD, 4, 4, 4, 4, -3, 1'b0, -1, 1'b1, 1'b0,
                                   ST_OK));
      // A CRC mismatch on the final byte still closes the set.
      directed_rows.push_back(plan(64'h21, 8'hEE, 0, 0, LEN_ABSENT, 0, 0, 1'b1, -1, 1'b1,
                                   1'b1, ST_CRC_BAD));

      reset_model();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         made = reports_made;
         send_row(directed_rows[r]);
         if (directed_rows[r].typed &&
             (reports_made == made || last_status != directed_rows[r].status)) begin
            mismatches++;
            $display("%0t ns: directed message %0d, expected status %0d, actual %0d",
                     $time, r, directed_rows[r].status, last_status);
         end
      end

      // Random sets of one to four messages, with the odd burst of raw noise. The first
      // stretch of random sets runs with neither side idling.
      calm_start = requests_taken;
      while (parsed_bytes < PARSED_TARGET || reports_made < REPORT_TARGET) begin
         calm <= (requests_taken - calm_start < CALM_BYTES);
         if ($urandom_range(19) == 0) begin
            n = $urandom_range(1, 40);
            for (int j = 0; j < n; j++) send_byte(8'($urandom_range(255)), j == n - 1);
         end else begin
            n = $urandom_range(1, 4);
            for (int k = 0; k < n; k++) begin
               m = random_row(k == n - 1);
               send_row(m);
               if (m.cut >= 0) break;
            end
         end
      end

      // Let every outstanding result drain, then watch a little longer for strays.
      req_valid <= 1'b0;
      while (reports_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests (%0d parsed, the rest skipped after errors); %0d results.",
               requests_taken, parsed_bytes, results_checked);
      $display("By status: ok %0d, crc %0d, size %0d, key %0d, value %0d, truncated %0d.",
               status_tally[0], status_tally[1], status_tally[2], status_tally[3],
               status_tally[4], status_tally[5]);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== message_set_deframer_crc_check.f =====
hdl/msd_pkg.sv
hdl/msd_core.sv
hdl/message_set_deframer_crc_check.sv
hdl/msd_chk.sv
dv/tb_message_set_deframer_crc_check.sv
